>>> hw/rtl/pac_pkg.sv
package pac_pkg;

   localparam int MAX_PATTERN = 64;
   localparam int BYTE_W      = 8;
   localparam int COUNT_BITS  = 16;
   localparam int RSP_BITS    = 16;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 1;
   localparam int RSP_DATA_W  = 24;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   typedef enum logic {
      ACT_PATTERN = 1'b0,
      ACT_TEXT    = 1'b1
   } action_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CASE_FOLD  = 1'b0,
      CSR_FIRST_ONLY = 1'b1
   } csr_index_type;

   // control broadcast to every cell of the row
   typedef struct packed {
      logic load;   // pattern byte shifts into the row
      logic text;   // text byte accepted
      logic last;   // text byte closes its block
      logic fold;   // ASCII case folding on both sides of the compare
   } ctrl_type;

   function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c,
                                                   input logic              en);
      logic [BYTE_W-1:0] r;
      r = c;
      if (en && c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/pattern_occurrence_counter.sv
// A block's result is registered when its last text byte is accepted.
// Throughput: one byte (pattern or text) per cycle; the row of 64 compare cells
// evaluates the whole window in the cycle the byte arrives.
// Stalls only when both the output register and the skid register hold results.
// Reset (synchronous, active high) clears pattern length, block fill, count,
// flags and configuration; pattern and window bytes are not cleared.
module pattern_occurrence_counter (
   input  logic                           clock,
   input  logic                           reset,
   // text / pattern input
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] data_byte
   input  logic                           req_tuser,   // [0] action
   input  logic                           req_tlast,   // last
   // per-block result
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [pac_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [15:0] match_count,
                                                       // [16] pattern_too_long
   // configuration
   input  logic                           csr_we,
   input  logic [pac_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [pac_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pac_pkg::*;

   // ---------------- configuration ----------------
   logic fold_ff, fold_in;
   logic first_ff, first_in;

   always_comb begin
      fold_in  = fold_ff;
      first_in = first_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_CASE_FOLD:  fold_in  = csr_wdata[0];
            CSR_FIRST_ONLY: first_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- input decode ----------------
   logic accept, pat_acc, txt_acc;
   logic restart, full, load;
   assign accept  = req_tvalid & req_tready;
   assign pat_acc = accept & (action_type'(req_tuser) == ACT_PATTERN);
   assign txt_acc = accept & (action_type'(req_tuser) == ACT_TEXT);

   logic prog_ff, prog_in;   // pattern load in progress
   logic ovf_ff, ovf_in;     // pattern truncated

   // act chain is a thermometer of pattern length: the last cell active means full
   logic [MAX_PATTERN-1:0] act_q;
   assign restart = !prog_ff;
   assign full    = act_q[MAX_PATTERN-1];
   // new pattern starts empty, so its first byte always loads
   assign load    = pat_acc & (restart | ~full);

   always_comb begin
      prog_in = prog_ff;
      ovf_in  = ovf_ff;
      if (pat_acc) begin
         prog_in = ~req_tlast;
         if (restart) begin
            ovf_in = 1'b0;
         end else if (full) begin
            ovf_in = 1'b1;
         end
      end
   end

   ctrl_type ctrl;
   assign ctrl.load = load;
   assign ctrl.text = txt_acc;
   assign ctrl.last = req_tlast;
   assign ctrl.fold = fold_ff;

   // ---------------- compare row ----------------
   // Cell j holds the j-th most recent pattern byte and compares it with the
   // j-th most recent text byte (cell 0 sees the arriving byte).
   logic [BYTE_W-1:0]      pat_q  [MAX_PATTERN];
   logic [BYTE_W-1:0]      text_q [MAX_PATTERN];
   logic [BYTE_W-1:0]      pat_src  [MAX_PATTERN];
   logic [BYTE_W-1:0]      text_src [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] act_src, seen_src, seen_q, ok;

   always_comb begin
      pat_src[0]  = req_tdata;
      text_src[0] = req_tdata;
      act_src[0]  = 1'b1;
      seen_src[0] = 1'b1;
      for (int j = 1; j < MAX_PATTERN; j++) begin
         pat_src[j]  = pat_q[j-1];
         text_src[j] = text_q[j-1];
         act_src[j]  = act_q[j-1] & ~restart;
         seen_src[j] = seen_q[j-1];
      end
   end

   for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
      pac_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .pat_src  (pat_src[g]),
         .act_src  (act_src[g]),
         .text_src (text_src[g]),
         .seen_src (seen_src[g]),
         .pat_q    (pat_q[g]),
         .act_q    (act_q[g]),
         .text_q   (text_q[g]),
         .seen_q   (seen_q[g]),
         .ok       (ok[g])
      );
   end

   // empty pattern never matches
   logic hit;
   assign hit = act_q[0] & (&ok);

   // ---------------- count ----------------
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in, cnt_now, cap;
   logic                  push;

   always_comb begin
      cap     = first_ff ? COUNT_ONE : COUNT_MAX;
      cnt_now = (hit && cnt_ff < cap) ? cnt_ff + COUNT_ONE : cnt_ff;
      push    = txt_acc & req_tlast;
      cnt_in  = cnt_ff;
      if (txt_acc) begin
         cnt_in = req_tlast ? '0 : cnt_now;
      end
   end

   logic [RSP_DATA_W-1:0] res;
   assign res = {{(RSP_DATA_W-RSP_BITS-1){1'b0}}, ovf_ff, RSP_BITS'(cnt_now)};

   // ---------------- output register + skid ----------------
   logic                  out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   logic [RSP_DATA_W-1:0] out_d_ff, out_d_in, skid_d_ff, skid_d_in;
   logic                  pop;

   assign pop        = out_v_ff & rsp_tready;
   assign req_tready = ~skid_v_ff;

   always_comb begin
      out_v_in  = out_v_ff;
      out_d_in  = out_d_ff;
      skid_v_in = skid_v_ff;
      skid_d_in = skid_d_ff;
      if (skid_v_ff) begin
         if (pop) begin
            out_d_in  = skid_d_ff;
            skid_v_in = 1'b0;
         end
      end else if (push) begin
         if (!out_v_ff || pop) begin
            out_v_in = 1'b1;
            out_d_in = res;
         end else begin
            skid_v_in = 1'b1;
            skid_d_in = res;
         end
      end else if (pop) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_d_ff  <= out_d_in;
      skid_d_ff <= skid_d_in;
      if (reset) begin
         fold_ff   <= 1'b0;
         first_ff  <= 1'b0;
         prog_ff   <= 1'b0;
         ovf_ff    <= 1'b0;
         cnt_ff    <= '0;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         fold_ff   <= fold_in;
         first_ff  <= first_in;
         prog_ff   <= prog_in;
         ovf_ff    <= ovf_in;
         cnt_ff    <= cnt_in;
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

endmodule

>>> hw/rtl/pac_cell.sv
// One position of the compare row: a pattern byte, a window byte, and
// thermometer bits for pattern length and block fill.
module pac_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  pac_pkg::ctrl_type         ctrl,
   input  logic [pac_pkg::BYTE_W-1:0] pat_src,
   input  logic                      act_src,
   input  logic [pac_pkg::BYTE_W-1:0] text_src,
   input  logic                      seen_src,
   output logic [pac_pkg::BYTE_W-1:0] pat_q,
   output logic                      act_q,
   output logic [pac_pkg::BYTE_W-1:0] text_q,
   output logic                      seen_q,
   output logic                      ok
);
   import pac_pkg::*;

   logic [BYTE_W-1:0] pat_ff, pat_in;
   logic [BYTE_W-1:0] text_ff, text_in;
   logic              act_ff, act_in;
   logic              seen_ff, seen_in;

   always_comb begin
      pat_in  = ctrl.load ? pat_src : pat_ff;
      act_in  = ctrl.load ? act_src : act_ff;
      text_in = ctrl.text ? text_src : text_ff;
      seen_in = ctrl.text ? (seen_src & ~ctrl.last) : seen_ff;
   end

   // inactive cells (past the pattern length) always agree
   assign ok = !act_ff ||
               (seen_src && (fold_byte(text_src, ctrl.fold) == fold_byte(pat_ff, ctrl.fold)));

   always_ff @(posedge clock) begin
      pat_ff  <= pat_in;
      text_ff <= text_in;
      if (reset) begin
         act_ff  <= 1'b0;
         seen_ff <= 1'b0;
      end else begin
         act_ff  <= act_in;
         seen_ff <= seen_in;
      end
   end

   assign pat_q  = pat_ff;
   assign act_q  = act_ff;
   assign text_q = text_ff;
   assign seen_q = seen_ff;

endmodule

>>> verif/pattern_occurrence_counter_test.sv
module pattern_occurrence_counter_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pac_pkg::*;

   // run length guard, far above the slowest legal run (~2k bytes with long
   // gaps on both sides and one long receiver hold)
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int          PHASE_ITEMS   = 180;   // random bytes per config setting
   localparam int          RANDOM_PHASES = 8;
   localparam int          LONG_HOLD     = 300;   // receiver back-pressure stretch
   localparam int          SETTLE_CYCLES = 4;     // each result is registered from its block's last byte

   typedef logic [7:0] octets_type[$];

   // one input item as the stream carries it
   typedef struct packed {
      action_type action;
      logic [7:0] data_byte;
      logic       last;
   } byte_item_type;

   // one per-block result
   typedef struct {
      logic [RSP_BITS-1:0] count;
      logic                too_long;
   } block_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;     // [7:0] data_byte
   logic                  req_tuser = 1'b0;   // [0] action
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // [15:0] match_count, [16] pattern_too_long
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = CSR_CASE_FOLD;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pattern_occurrence_counter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Search predictor: own copy of pattern, window history and settings
   // ---------------------------------------------------------------------
   logic [7:0]  pat_bytes [MAX_PATTERN];
   int unsigned pat_len   = 0;
   bit          pat_open  = 1'b0;    // pattern load started, last byte not seen
   bit          pat_trunc = 1'b0;    // bytes dropped past MAX_PATTERN
   logic [7:0]  history [MAX_PATTERN-1] = '{default: '0};  // [0] = newest text byte
   int unsigned block_fill = 0;      // text bytes seen in block, capped
   int unsigned block_hits = 0;
   bit          fold_on  = 1'b0;
   bit          first_on = 1'b0;

   block_result_type expected_counts[$];
   byte_item_type    feed_queue[$];
   int               items_queued = 0;
   int               items_taken  = 0;
   int               fail_count   = 0;

   // sender / receiver idling controls
   bit            send_idle_on = 1'b1;
   bit            take_idle_on = 1'b1;
   int            send_stall   = 0;
   int            take_stall   = 0;
   int            hold_asked   = 0;
   int            hold_served  = 0;
   int unsigned   cycle_count  = 0;
   byte_item_type drive_item;

   function automatic logic [7:0] to_upper(logic [7:0] c);
      if (fold_on && c >= 8'h61 && c <= 8'h7A) begin
         return c - 8'h20;
      end
      return c;
   endfunction

   // window = current byte plus pat_len-1 previous bytes of this block
   function automatic bit window_hit(logic [7:0] cur);
      int unsigned i;
      if (pat_len == 0 || block_fill < pat_len) begin
         return 1'b0;
      end
      if (to_upper(cur) != to_upper(pat_bytes[pat_len-1])) begin
         return 1'b0;
      end
      for (i = 0; i + 1 < pat_len; i++) begin
         if (to_upper(history[i]) != to_upper(pat_bytes[pat_len-2-i])) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic void predict_item(byte_item_type it);
      int unsigned      cap;
      int               i;
      block_result_type res;
      if (it.action == ACT_PATTERN) begin
         // first byte of a new pattern wipes length and overflow flag
         if (!pat_open) begin
            pat_len   = 0;
            pat_trunc = 1'b0;
         end
         if (pat_len < MAX_PATTERN) begin
            pat_bytes[pat_len] = it.data_byte;
            pat_len++;
         end else begin
            pat_trunc = 1'b1;
         end
         pat_open = !it.last;
         return;
      end
      if (block_fill < MAX_PATTERN) begin
         block_fill++;
      end
      if (window_hit(it.data_byte)) begin
         cap = first_on ? 1 : COUNT_MAX;
         if (block_hits < cap) begin
            block_hits++;
         end
      end
      for (i = MAX_PATTERN - 2; i > 0; i--) begin
         history[i] = history[i-1];
      end
      history[0] = it.data_byte;
      if (it.last) begin
         res.count    = block_hits[RSP_BITS-1:0];
         res.too_long = pat_trunc;
         expected_counts.push_back(res);
         block_hits = 0;
         block_fill = 0;
      end
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      // keep the log readable if everything goes wrong
      if (fail_count < 100) begin
         $display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
      end
      fail_count++;
   endtask

   task automatic check_block_result(logic [RSP_DATA_W-1:0] data);
      block_result_type want;
      if (expected_counts.size() == 0) begin
         report_mismatch("result with no open block", 32'(data), 0);
         return;
      end
      want = expected_counts.pop_front();
      if (data[RSP_BITS-1:0] !== want.count) begin
         report_mismatch("match_count", 32'(data[RSP_BITS-1:0]), 32'(want.count));
      end
      if (data[RSP_BITS] !== want.too_long) begin
         report_mismatch("pattern_too_long", 32'(data[RSP_BITS]), 32'(want.too_long));
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic void queue_item(action_type a, logic [7:0] d, logic l);
      byte_item_type it;
      it.action    = a;
      it.data_byte = d;
      it.last      = l;
      feed_queue.push_back(it);
      items_queued++;
   endfunction

   function automatic void queue_pattern(octets_type p);
      foreach (p[i]) queue_item(ACT_PATTERN, p[i], i == p.size() - 1);
   endfunction

   function automatic void queue_text(octets_type t, bit closes);
      foreach (t[i]) queue_item(ACT_TEXT, t[i], closes && i == t.size() - 1);
   endfunction

   function automatic octets_type octets(string s);
      octets_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   // narrow alphabet (any byte when wide): mostly a/A/b/B so matches and overlaps are common,
   // plus the characters just outside the fold range and the range ends
   function automatic logic [7:0] pick_char(bit wide);
      logic [7:0] edge_chars [6] = '{8'h60, 8'h7B, 8'h40, 8'h5B, 8'h7A, 8'h5A};
      int         r;
      if (wide) begin
         return 8'($urandom_range(0, 255));
      end
      r = $urandom_range(0, 21);
      if (r < 16) begin
         return (r[0] ? 8'h41 : 8'h61) + 8'(r[1]);
      end
      return edge_chars[r-16];
   endfunction

   function automatic octets_type random_text(int n, bit wide);
      octets_type q;
      repeat (n) q.push_back(pick_char(wide));
      return q;
   endfunction

   function automatic logic [7:0] flip_case(logic [7:0] c);
      if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
          && $urandom_range(0, 2) == 0) begin
         return c ^ 8'h20;
      end
      return c;
   endfunction

   function automatic int pick_pattern_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return $urandom_range(1, 4);
      if (r < 88) return $urandom_range(5, 12);
      if (r < 97) return $urandom_range(13, MAX_PATTERN);
      return $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 6);   // overflows
   endfunction

   // gap lengths: mostly short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // load a pattern, then stream 1..4 blocks with planted (case-flipped)
   // copies; a few rounds break up the load or the block with the other kind
   task automatic queue_search_round(bit wide);
      octets_type pat;
      octets_type txt;
      int         plen, nblk, tlen, at, cut, b, j;
      plen = pick_pattern_length();
      pat  = random_text(plen, wide);
      if (plen > 1 && $urandom_range(0, 19) == 0) begin
         // text bytes arriving mid-load see the partial pattern
         cut = $urandom_range(1, plen - 1);
         for (j = 0; j < cut; j++) queue_item(ACT_PATTERN, pat[j], 1'b0);
         queue_text(random_text($urandom_range(1, 3), wide), 1'($urandom_range(0, 1)));
         for (j = cut; j < plen; j++) queue_item(ACT_PATTERN, pat[j], j == plen - 1);
      end else begin
         queue_pattern(pat);
      end
      nblk = $urandom_range(1, 4);
      for (b = 0; b < nblk; b++) begin
         tlen = (plen > 12) ? plen + $urandom_range(0, 16) : $urandom_range(1, 24);
         txt  = random_text(tlen, wide);
         repeat ($urandom_range(0, 2)) begin
            if (tlen >= plen) begin
               at = $urandom_range(0, tlen - plen);
               for (j = 0; j < plen; j++) txt[at+j] = flip_case(pat[j]);
            end
         end
         // occasionally swap the pattern in the middle of a block
         cut = (tlen > 1 && $urandom_range(0, 11) == 0) ? $urandom_range(1, tlen - 1) : 0;
         for (j = 0; j < tlen; j++) begin
            if (cut != 0 && j == cut) begin
               queue_pattern(random_text($urandom_range(1, 3), wide));
            end
            queue_item(ACT_TEXT, txt[j], j == tlen - 1);
         end
      end
   endtask

   // sender pause: everything accepted and every block result back
   task automatic wait_idle();
      do @(negedge clock);
      while (items_taken != items_queued || expected_counts.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Driver: next item from feed_queue, unless a gap is pending, whenever the slot is free
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (send_stall > 0) begin
            send_stall <= send_stall - 1;
            req_tvalid <= 1'b0;
         end else if (feed_queue.size() != 0) begin
            drive_item = feed_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= drive_item.action;
            req_tdata  <= drive_item.data_byte;
            req_tlast  <= drive_item.last;
            send_stall <= (send_idle_on && $urandom_range(0, 9) < 3) ? pick_gap() : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold on request so the result
   // register and skid fill up and the input gets back-pressured
   always @(posedge clock) begin
      if (hold_served != hold_asked) begin
         hold_served <= hold_served + 1;
         take_stall  <= LONG_HOLD;
         rsp_tready  <= 1'b0;
      end else if (take_stall > 0) begin
         take_stall <= take_stall - 1;
         rsp_tready <= 1'b0;
      end else if (take_idle_on && $urandom_range(0, 9) < 3) begin
         take_stall <= pick_gap() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: results checked before this edge's input is predicted, since
   // a result can never come from the byte accepted on the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            check_block_result(rsp_tdata);
         end
         if (req_tvalid && req_tready) begin
            predict_item('{action_type'(req_tuser), req_tdata, req_tlast});
            items_taken++;
         end
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_CASE_FOLD:  fold_on  = csr_wdata[0];
               CSR_FIRST_ONLY: first_on = csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("pattern_occurrence_counter_test NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      int         phase;
      int         phase_start;
      octets_type full;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // nothing loaded yet: empty pattern never matches
      queue_text(octets("ab"), 1'b1);
      // overlapping hits, case sensitive: "aaaA" has two "aa"
      queue_pattern(octets("aa"));
      queue_text(octets("aaaA"), 1'b1);
      wait_idle();

      write_reg(CSR_CASE_FOLD, 1'b1);
      queue_text(octets("AaA"), 1'b1);                  // folded: two hits
      // byte extremes
      queue_item(ACT_PATTERN, 8'h00, 1'b0);
      queue_item(ACT_PATTERN, 8'hFF, 1'b1);
      queue_text('{8'hFF, 8'h00, 8'hFF}, 1'b1);
      // just outside a-z must not fold onto @ or [
      queue_pattern('{8'h60, 8'h7B});
      queue_text('{8'h40, 8'h5B, 8'h60, 8'h7B}, 1'b1);
      // fold range ends
      queue_pattern(octets("az"));
      queue_text(octets("AZ"), 1'b1);
      wait_idle();

      write_reg(CSR_FIRST_ONLY, 1'b1);
      queue_pattern(octets("a"));
      queue_text(octets("aaa"), 1'b1);                  // capped at one
      wait_idle();

      write_reg(CSR_FIRST_ONLY, 1'b0);
      // text while the pattern is half loaded, then the load completes
      queue_item(ACT_PATTERN, "x", 1'b0);
      queue_text(octets("x"), 1'b1);
      queue_item(ACT_PATTERN, "y", 1'b1);
      // new pattern inside a block: window and count carry over
      queue_text(octets("xy"), 1'b0);
      queue_pattern(octets("q"));
      queue_text(octets("q"), 1'b1);
      // too long pattern, then a fresh load clears the flag
      queue_pattern(random_text(MAX_PATTERN + 2, 1'b1));
      queue_text(octets("b"), 1'b1);
      queue_pattern(octets("b"));
      queue_text(octets("b"), 1'b1);
      // full-length pattern in a block of exactly its size
      full = random_text(MAX_PATTERN, 1'b1);
      queue_pattern(full);
      queue_text(full, 1'b1);
      wait_idle();

      // random phases, each under its own register setting
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         send_idle_on = (phase % 3) != 0 && phase != 2;
         take_idle_on = (phase % 3) != 0;
         write_reg(CSR_CASE_FOLD,  phase < 4 ? phase[0] : 1'($urandom_range(0, 1)));
         write_reg(CSR_FIRST_ONLY, phase < 4 ? phase[1] : 1'($urandom_range(0, 1)));
         if (phase == 2) begin
            hold_asked++;
         end
         phase_start = items_queued;
         while (items_queued - phase_start < PHASE_ITEMS) begin
            queue_search_round($urandom_range(0, 9) < 3);
         end
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("pattern_occurrence_counter_test OK");
      end else begin
         $display("pattern_occurrence_counter_test NOT OK");
      end
      $finish;
   end

endmodule
